@@ hdl/rrpm_pkg.sv @@
package rrpm_pkg;

    // Slot table geometry, fixed by the packed register layout
    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = 3;
    localparam int ID_W      = 8;
    localparam int MAX_NODES = 8;

    // Configuration register indexes
    localparam logic [2:0] CFG_NODE_COUNT   = 3'd0;
    localparam logic [2:0] CFG_SLOT_VALID   = 3'd1;
    localparam logic [2:0] CFG_SLOT_IDS     = 3'd2;
    localparam logic [2:0] CFG_POLL_INTV    = 3'd3;
    localparam logic [2:0] CFG_RESP_TIMEOUT = 3'd4;

    // Input action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_REPLY = 2'd1;
    localparam logic [1:0] ACT_FAIL  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEND = 2'd1,
        PH_WAIT = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_REQUEST    = 3'd1,
        EV_ACCEPT     = 3'd2,
        EV_OFFLINE    = 3'd3,
        EV_UNKNOWN    = 3'd4,
        EV_UNEXPECTED = 3'd5,
        EV_SKIPPED    = 3'd6
    } event_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } slot_match_t;

    typedef struct packed {
        event_t             event_res;
        logic [ID_W-1:0]    node_id;
        logic [15:0]        seq_number;
        logic [31:0]        response_time_ms;
        logic [NUM_SLOTS-1:0] online_nodes;
    } result_t;

endpackage

@@ hdl/rrpm_slot_lookup.sv @@
module rrpm_slot_lookup (
    input  logic [rrpm_pkg::NUM_SLOTS-1:0]                slot_ok,
    input  logic [rrpm_pkg::NUM_SLOTS*rrpm_pkg::ID_W-1:0] slot_ids,
    input  logic [rrpm_pkg::ID_W-1:0]                     key,
    output rrpm_pkg::slot_match_t                         match
);
    import rrpm_pkg::*;

    // Find the lowest valid slot holding the key
    always_comb begin
        match.hit  = 1'b0;
        match.slot = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (slot_ok[i] && (slot_ids[i*ID_W +: ID_W] == key)) begin
                match.hit  = 1'b1;
                match.slot = SLOT_W'(i);
            end
        end
    end

endmodule

@@ hdl/round_robin_poll_master.sv @@
// Each input transfer's result is registered before it is presented. Throughput:
// one input transfer per cycle while s_ready is high; event decoding and state
// update happen in one pass between the state registers and the result register.
// A skid entry behind the result register keeps s_ready high while one result
// waits; s_ready is low only in reset or while the skid entry is occupied.
// Reset (aresetn low, synchronous): state, flags and configuration take defaults.
module round_robin_poll_master (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_reply_node,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [7:0]  m_node_id,
    output logic [15:0] m_seq_number,
    output logic [31:0] m_response_time_ms,
    output logic [7:0]  m_online_nodes
);
    import rrpm_pkg::*;

    // configuration registers
    logic [3:0]              node_count_reg;
    logic [NUM_SLOTS-1:0]    slot_valid_reg;
    logic [NUM_SLOTS*ID_W-1:0] slot_ids_reg;
    logic [31:0]             poll_intv_reg;
    logic [31:0]             resp_timeout_reg;

    // poll state
    phase_t               phase_reg, phase_next;
    logic [SLOT_W-1:0]    slot_index_reg, slot_index_next;
    logic [15:0]          seq_reg, seq_next;
    logic [31:0]          clock_reg, clock_next;
    logic [31:0]          phase_stamp_reg, phase_stamp_next;
    logic [31:0]          req_stamp_reg, req_stamp_next;
    logic [NUM_SLOTS-1:0] online_reg, online_next;

    // output stage
    result_t out_reg, skid_reg, result;
    logic    m_valid_reg, skid_valid_reg;

    logic                 accept;
    logic [3:0]           eff_count;
    logic [NUM_SLOTS-1:0] slot_ok;
    logic                 cur_ok;
    logic [ID_W-1:0]      cur_id;
    logic [ID_W-1:0]      lookup_key;
    slot_match_t          match;
    logic [3:0]           idx_plus;
    logic [SLOT_W-1:0]    adv_index;
    logic [31:0]          clock_inc;
    logic                 is_tick, is_reply, is_fail;
    logic                 idle_due, wait_due;
    logic                 go_send, do_skip, do_request, do_drop, do_accept;
    logic                 reply_unknown, reply_unexp, do_advance, cur_match;

    assign accept  = s_valid && s_ready;
    assign s_ready = aresetn && !skid_valid_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg   <= 4'd8;
            slot_valid_reg   <= '0;
            slot_ids_reg     <= '0;
            poll_intv_reg    <= 32'd1000;
            resp_timeout_reg <= 32'd200;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NODE_COUNT:   node_count_reg   <= cfg_wdata[3:0];
                CFG_SLOT_VALID:   slot_valid_reg   <= cfg_wdata[NUM_SLOTS-1:0];
                CFG_SLOT_IDS:     slot_ids_reg     <= cfg_wdata;
                CFG_POLL_INTV:    poll_intv_reg    <= cfg_wdata[31:0];
                CFG_RESP_TIMEOUT: resp_timeout_reg <= cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    // slot qualification
    always_comb begin
        eff_count = (node_count_reg < 4'(MAX_NODES)) ? node_count_reg : 4'(MAX_NODES);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_ok[i] = (4'(i) < eff_count) && slot_valid_reg[i];
        end
    end

    assign cur_ok     = slot_ok[slot_index_reg];
    assign cur_id     = slot_ids_reg[{slot_index_reg, 3'b000} +: ID_W];
    assign lookup_key = (s_action == ACT_REPLY) ? s_reply_node : cur_id;

    rrpm_slot_lookup u_lookup (
        .slot_ok  (slot_ok),
        .slot_ids (slot_ids_reg),
        .key      (lookup_key),
        .match    (match)
    );

    // next slot in the rotation
    assign idx_plus  = {1'b0, slot_index_reg} + 4'd1;
    assign adv_index = (idx_plus >= eff_count) ? '0 : idx_plus[SLOT_W-1:0];

    // decode the transfer into events
    always_comb begin
        is_tick       = (s_action == ACT_TICK);
        is_reply      = (s_action == ACT_REPLY);
        is_fail       = (s_action == ACT_FAIL);
        clock_inc     = clock_reg + 32'd1;
        idle_due      = (clock_inc - phase_stamp_reg) >= poll_intv_reg;
        wait_due      = (clock_inc - req_stamp_reg) >= resp_timeout_reg;
        cur_match     = cur_ok && (cur_id == s_reply_node);
        go_send       = is_tick && (phase_reg == PH_IDLE) && idle_due;
        do_skip       = is_tick && (phase_reg == PH_SEND) && !cur_ok;
        do_request    = is_tick && (phase_reg == PH_SEND) && cur_ok;
        do_drop       = (phase_reg == PH_WAIT) && ((is_tick && wait_due) || is_fail);
        reply_unknown = is_reply && !match.hit;
        reply_unexp   = is_reply && match.hit && !cur_match;
        do_accept     = is_reply && match.hit && cur_match;
        do_advance    = do_skip || do_drop || do_accept;
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (go_send) phase_next = PH_SEND;
            end
            PH_SEND: begin
                if (do_request) phase_next = PH_WAIT;
                else if (do_skip) phase_next = PH_IDLE;
            end
            PH_WAIT: begin
                if (do_drop) phase_next = PH_IDLE;
            end
            default: begin
                if (is_tick) phase_next = PH_IDLE;
            end
        endcase
        if (do_accept) phase_next = PH_IDLE;
    end

    // next counters, stamps and online mask
    always_comb begin
        clock_next       = is_tick ? clock_inc : clock_reg;
        slot_index_next  = do_advance ? adv_index : slot_index_reg;
        phase_stamp_next = do_advance ? clock_next : phase_stamp_reg;
        req_stamp_next   = do_request ? clock_inc : req_stamp_reg;
        seq_next         = do_request ? seq_reg + 16'd1 : seq_reg;
        online_next      = online_reg;
        if (do_accept) begin
            online_next[match.slot] = 1'b1;
        end else if (do_drop && cur_ok && match.hit) begin
            online_next[match.slot] = 1'b0;
        end
    end

    // result fields
    always_comb begin
        result.event_res        = EV_NONE;
        result.node_id          = '0;
        result.seq_number       = '0;
        result.response_time_ms = '0;
        result.online_nodes     = online_next;
        if (do_request) begin
            result.event_res  = EV_REQUEST;
            result.node_id    = cur_id;
            result.seq_number = seq_next;
        end else if (do_skip) begin
            result.event_res = EV_SKIPPED;
        end else if (do_drop && cur_ok) begin
            result.event_res = EV_OFFLINE;
            result.node_id   = cur_id;
        end else if (reply_unknown) begin
            result.event_res = EV_UNKNOWN;
            result.node_id   = s_reply_node;
        end else if (reply_unexp) begin
            result.event_res = EV_UNEXPECTED;
            result.node_id   = s_reply_node;
        end else if (do_accept) begin
            result.event_res        = EV_ACCEPT;
            result.node_id          = s_reply_node;
            result.response_time_ms = clock_reg - req_stamp_reg;
        end
    end

    // commit state on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            slot_index_reg  <= '0;
            seq_reg         <= '0;
            clock_reg       <= '0;
            phase_stamp_reg <= '0;
            req_stamp_reg   <= '0;
            online_reg      <= '0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            slot_index_reg  <= slot_index_next;
            seq_reg         <= seq_next;
            clock_reg       <= clock_next;
            phase_stamp_reg <= phase_stamp_next;
            req_stamp_reg   <= req_stamp_next;
            online_reg      <= online_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg    <= skid_valid_reg || accept;
                skid_valid_reg <= 1'b0;
            end else if (accept) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) out_reg <= skid_reg;
            else if (accept) out_reg <= result;
        end else if (accept) begin
            skid_reg <= result;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_event_res        = out_reg.event_res;
    assign m_node_id          = out_reg.node_id;
    assign m_seq_number       = out_reg.seq_number;
    assign m_response_time_ms = out_reg.response_time_ms;
    assign m_online_nodes     = out_reg.online_nodes;

`ifndef SYNTHESIS
    // skid entry is only used behind a pending result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry occupied with empty output register");

    // sequence counter moves only with an issued request
    a_seq_on_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (seq_next != seq_reg)) |-> (result.event_res == EV_REQUEST))
        else $error("sequence counter changed without a request");

    // online mask changes only on accepted reply or offline event
    a_online_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (online_next != online_reg)) |->
        ((result.event_res == EV_ACCEPT) || (result.event_res == EV_OFFLINE)))
        else $error("online mask changed on an unrelated event");

    // advancing events return to idle
    a_advance_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && do_advance) |=> (phase_reg == PH_IDLE))
        else $error("advance did not return to idle");
`endif

endmodule

@@ tb/tb_round_robin_poll_master.sv @@
import rrpm_pkg::*;

// Shadow of the polling master plus a queue of the results it owes
class poll_scoreboard;
    // register copy
    bit [3:0]  node_count;
    bit [7:0]  slot_valid_mask;
    bit [63:0] slot_node_ids;
    bit [31:0] poll_gap_ms;
    bit [31:0] reply_limit_ms;

    // polling state
    phase_t    phase;
    bit [2:0]  slot_index;
    bit [15:0] seq_counter;
    bit [31:0] clock_ms;
    bit [31:0] phase_stamp;
    bit [31:0] request_stamp;
    bit [7:0]  online_mask;

    result_t     pending_events[$];
    int unsigned failures;
    int unsigned transfers_in;
    int unsigned event_tally[8];

    function new();
        node_count      = 4'd8;
        slot_valid_mask = '0;
        slot_node_ids   = '0;
        poll_gap_ms     = 32'd1000;
        reply_limit_ms  = 32'd200;
        phase           = PH_IDLE;
        slot_index      = '0;
        seq_counter     = '0;
        clock_ms        = '0;
        phase_stamp     = '0;
        request_stamp   = '0;
        online_mask     = '0;
        failures        = 0;
        transfers_in    = 0;
    endfunction

    function void write_register(logic [2:0] idx, logic [63:0] value);
        case (idx)
            CFG_NODE_COUNT:   node_count      = value[3:0];
            CFG_SLOT_VALID:   slot_valid_mask = value[7:0];
            CFG_SLOT_IDS:     slot_node_ids   = value;
            CFG_POLL_INTV:    poll_gap_ms     = value[31:0];
            CFG_RESP_TIMEOUT: reply_limit_ms  = value[31:0];
            default: ;
        endcase
    endfunction

    function int active_slots();
        return (node_count < MAX_NODES) ? int'(node_count) : MAX_NODES;
    endfunction

    function bit holds_node(int s);
        return (s < active_slots()) && slot_valid_mask[s];
    endfunction

    function bit [7:0] id_of(int s);
        return slot_node_ids[s*8 +: 8];
    endfunction

    // Lowest valid slot carrying the id, NUM_SLOTS when none does
    function int lowest_slot_of(bit [7:0] id);
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (holds_node(s) && id_of(s) == id) return s;
        end
        return NUM_SLOTS;
    endfunction

    // Move to the next slot, wrapping at the active count, and go idle
    function void next_slot();
        if (int'(slot_index) + 1 >= active_slots()) begin
            slot_index = '0;
        end else begin
            slot_index = slot_index + 3'd1;
        end
        phase_stamp = clock_ms;
        phase       = PH_IDLE;
    endfunction

    // Mark the polled node offline (if the slot still holds one) and advance
    function event_t take_offline(output bit [7:0] id);
        int     s;
        event_t ev;
        ev = EV_NONE;
        id = '0;
        if (holds_node(slot_index)) begin
            id = id_of(slot_index);
            s  = lowest_slot_of(id);
            if (s < NUM_SLOTS) online_mask[s] = 1'b0;
            ev = EV_OFFLINE;
        end
        next_slot();
        return ev;
    endfunction

    // Work out the result owed for one accepted input transfer
    function void note_transfer(logic [1:0] action, logic [7:0] reply);
        result_t  r;
        int       s;
        bit [7:0] id;
        r = '0;
        id = '0;
        transfers_in++;
        case (action)
            ACT_TICK: begin
                clock_ms = clock_ms + 32'd1;
                case (phase)
                    PH_IDLE: begin
                        if (clock_ms - phase_stamp >= poll_gap_ms) phase = PH_SEND;
                    end
                    PH_SEND: begin
                        if (!holds_node(slot_index)) begin
                            r.event_res = EV_SKIPPED;
                            next_slot();
                        end else begin
                            seq_counter   = seq_counter + 16'd1;
                            r.seq_number  = seq_counter;
                            r.node_id     = id_of(slot_index);
                            r.event_res   = EV_REQUEST;
                            request_stamp = clock_ms;
                            phase         = PH_WAIT;
                        end
                    end
                    PH_WAIT: begin
                        if (clock_ms - request_stamp >= reply_limit_ms) begin
                            r.event_res = take_offline(id);
                            r.node_id   = id;
                        end
                    end
                    default: phase = PH_IDLE;
                endcase
            end
            ACT_REPLY: begin
                s = lowest_slot_of(reply);
                r.node_id = reply;
                if (s >= NUM_SLOTS) begin
                    r.event_res = EV_UNKNOWN;
                end else if (!holds_node(slot_index) || id_of(slot_index) != reply) begin
                    r.event_res = EV_UNEXPECTED;
                end else begin
                    online_mask[s]     = 1'b1;
                    r.response_time_ms = clock_ms - request_stamp;
                    r.event_res        = EV_ACCEPT;
                    next_slot();
                end
            end
            ACT_FAIL: begin
                if (phase == PH_WAIT) begin
                    r.event_res = take_offline(id);
                    r.node_id   = id;
                end
            end
            default: ;
        endcase
        r.online_nodes = online_mask;
        pending_events.push_back(r);
    endfunction

    // Compare one result transfer with the oldest owed result
    function void check_event(result_t got);
        result_t want;
        if (pending_events.size() == 0) begin
            $error("result transfer with nothing owed: event_res %0d node_id %0h",
                   got.event_res, got.node_id);
            failures++;
            return;
        end
        want = pending_events.pop_front();
        event_tally[want.event_res]++;
        if (got.event_res !== want.event_res) begin
            $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
            failures++;
        end
        if (got.node_id !== want.node_id) begin
            $error("node_id: expected %0h, got %0h", want.node_id, got.node_id);
            failures++;
        end
        if (got.seq_number !== want.seq_number) begin
            $error("seq_number: expected %0d, got %0d", want.seq_number, got.seq_number);
            failures++;
        end
        if (got.response_time_ms !== want.response_time_ms) begin
            $error("response_time_ms: expected %0d, got %0d",
                   want.response_time_ms, got.response_time_ms);
            failures++;
        end
        if (got.online_nodes !== want.online_nodes) begin
            $error("online_nodes: expected %b, got %b", want.online_nodes, got.online_nodes);
            failures++;
        end
    endfunction
endclass

module tb_round_robin_poll_master;

    localparam logic [1:0] ACT_UNUSED    = 2'd3;
    localparam int         QUIET_LIMIT   = 2000;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         RANDOM_PHASES = 9;
    localparam int         PHASE_ITEMS   = 170;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [2:0]  cfg_index    = '0;
    logic [63:0] cfg_wdata    = '0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action     = '0;
    logic [7:0]  s_reply_node = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [2:0]  m_event_res;
    logic [7:0]  m_node_id;
    logic [15:0] m_seq_number;
    logic [31:0] m_response_time_ms;
    logic [7:0]  m_online_nodes;

    poll_scoreboard sb;
    result_t        seen_result;
    int             quiet_cycles   = 0;
    int             send_gap_pct   = 0;
    int             recv_stall_pct = 0;

    round_robin_poll_master u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_reply_node       (s_reply_node),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_res        (m_event_res),
        .m_node_id          (m_node_id),
        .m_seq_number       (m_seq_number),
        .m_response_time_ms (m_response_time_ms),
        .m_online_nodes     (m_online_nodes)
    );

    always #6 aclk = ~aclk;

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Check result transfers and count cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_result.event_res        = event_t'(m_event_res);
            seen_result.node_id          = m_node_id;
            seen_result.seq_number       = m_seq_number;
            seen_result.response_time_ms = m_response_time_ms;
            seen_result.online_nodes     = m_online_nodes;
            sb.check_event(seen_result);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Abort when the block stops moving
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    // Present one item, hold it until the transfer, then record it
    task automatic drive_event(logic [1:0] act, logic [7:0] node);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_reply_node <= node;
        do @(posedge aclk); while (!s_ready);
        sb.note_transfer(act, node);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_register(idx, value);
    endtask

    task automatic load_settings(logic [3:0] nc, logic [7:0] mask, logic [63:0] ids,
                                 logic [31:0] poll, logic [31:0] tmo);
        write_reg(CFG_NODE_COUNT, 64'(nc));
        write_reg(CFG_SLOT_VALID, 64'(mask));
        write_reg(CFG_SLOT_IDS, ids);
        write_reg(CFG_POLL_INTV, 64'(poll));
        write_reg(CFG_RESP_TIMEOUT, 64'(tmo));
        cfg_wr_en <= 1'b0;
    endtask

    // Drop valid and wait until every owed result has come out
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly ticks and replies from the polled node, plus stray traffic
    task automatic run_random(int n);
        logic [1:0] act;
        logic [7:0] node;
        int         pick;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            node = 8'($urandom_range(0, 255));
            if (pick < 58) begin
                act = ACT_TICK;
            end else if (pick < 78) begin
                act  = ACT_REPLY;
                node = sb.id_of(sb.slot_index);
            end else if (pick < 85) begin
                act  = ACT_REPLY;
                node = sb.id_of(int'($urandom_range(0, 7)));
            end else if (pick < 90) begin
                act = ACT_REPLY;
            end else if (pick < 96) begin
                act = ACT_FAIL;
            end else begin
                act = ACT_UNUSED;
            end
            drive_event(act, node);
        end
    endtask

    initial begin
        logic [3:0]  nc;
        logic [7:0]  mask;
        logic [63:0] ids;
        logic [31:0] poll;
        logic [31:0] tmo;

        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Four slots, slot 2 empty, slot 3 repeats the id of slot 1
        load_settings(4'd4, 8'b0000_1011, 64'h0000_0000_FF55_FF00, 32'd1, 32'd2);
        drive_event(ACT_TICK, 8'h00);
        drive_event(ACT_TICK, 8'hFF);     // request to slot 0
        drive_event(ACT_REPLY, 8'h55);    // id only in an empty slot
        drive_event(ACT_REPLY, 8'hFF);    // valid node, not the polled one
        drive_event(ACT_REPLY, 8'h00);    // accepted
        drive_event(ACT_FAIL, 8'hFF);     // send failure while idle
        drive_event(ACT_UNUSED, 8'h00);
        repeat (4) drive_event(ACT_TICK, 8'hFF);  // request slot 1, then time out
        repeat (2) drive_event(ACT_TICK, 8'h00);  // empty slot 2 is skipped
        repeat (3) drive_event(ACT_TICK, 8'hFF);  // request slot 3
        drive_event(ACT_REPLY, 8'hFF);    // duplicate id marks slot 1 online
        repeat (2) drive_event(ACT_TICK, 8'h00);  // request slot 0 and wait
        settle();

        // Empty the slot being waited on, then fail and reply around it
        load_settings(4'd4, 8'b0000_1010, 64'h0000_0000_FF55_FF00, 32'd1, 32'd2);
        drive_event(ACT_FAIL, 8'h00);     // wait on an empty slot gives no event
        drive_event(ACT_REPLY, 8'hFF);    // accepted while idle
        drive_event(ACT_REPLY, 8'h00);    // id no longer in a valid slot
        drive_event(ACT_REPLY, 8'hFF);    // polled slot is empty
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p / 3)
                0:       begin send_gap_pct = 35; recv_stall_pct = 66; end
                1:       begin send_gap_pct = 66; recv_stall_pct = 35; end
                default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            endcase
            nc   = 4'($urandom_range(1, 15));
            mask = 8'($urandom_range(0, 255));
            poll = 32'($urandom_range(0, 4));
            tmo  = 32'($urandom_range(0, 6));
            ids  = {$urandom, $urandom};
            // crowd ids into a few values so duplicates are common
            if (p % 3 == 1) begin
                for (int b = 0; b < NUM_SLOTS; b++) ids[b*8 +: 8] = 8'($urandom_range(0, 3));
            end
            case (p)
                0: begin nc = 4'd8; mask = 8'hFF; poll = '0; tmo = 32'd3; end
                1: begin nc = 4'd15; poll = '1; end
                2: begin nc = 4'd0; tmo = '0; end
                3: begin nc = 4'd1; mask = 8'h01; end
                4: begin poll = 32'd1; tmo = '1; end
                5: begin mask = 8'h00; ids = '0; end
                8: begin ids = '1; mask = 8'hFF; end
                default: ;
            endcase
            load_settings(nc, mask, ids, poll, tmo);
            run_random(PHASE_ITEMS);
            settle();
        end

        $display("covered %0d input transfers over %0d register settings", sb.transfers_in,
                 RANDOM_PHASES + 2);
        $display("results: request %0d, accept %0d, offline %0d, unknown %0d, "
                 , sb.event_tally[EV_REQUEST], sb.event_tally[EV_ACCEPT],
                 sb.event_tally[EV_OFFLINE], sb.event_tally[EV_UNKNOWN],
                 "unexpected %0d, skipped %0d, none %0d",
                 sb.event_tally[EV_UNEXPECTED], sb.event_tally[EV_SKIPPED],
                 sb.event_tally[EV_NONE]);
        if (sb.failures == 0 && sb.pending_events.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
